### design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

### design/bcra_pkg.sv
// Constants and codes for the cluster bitmap run allocator.
package bcra_pkg;

    localparam int MAP_BYTES    = 128;
    localparam int MAX_RUN      = 32;
    localparam int MAX_SEGMENTS = 57;

    localparam int NUM_CLUSTERS = MAP_BYTES * 8;
    localparam int ADDR_W       = $clog2(MAP_BYTES);
    localparam int CLU_W        = $clog2(NUM_CLUSTERS);
    localparam int RUN_W        = $clog2(MAX_RUN + 1);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 7;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int WORD_W  = 16;
    localparam int REM_W   = COUNT_W - 1;

    localparam int              LEN_SHIFT = 10;
    localparam logic [WORD_W-1:0] END_MARK  = 16'h8000;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_ALLOC = 2'd2
    } kind_t;

endpackage

### design/bcra_if.sv
// Request and result channel interfaces of the allocator.
interface bcra_req_if;
    import bcra_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] sector_count;

    modport source (output valid, kind, byte_index, byte_value, sector_count, input ready);
    modport sink   (input valid, kind, byte_index, byte_value, sector_count, output ready);
endinterface

interface bcra_res_if;
    import bcra_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] descriptor_word;
    logic [BYTE_W-1:0] read_byte;
    logic              status;
    logic              is_last;

    modport source (output valid, descriptor_word, read_byte, status, is_last, input ready);
    modport sink   (input valid, descriptor_word, read_byte, status, is_last, output ready);
endinterface

### design/bitmap_cluster_run_allocator.sv
// Cluster bitmap allocator: byte access to the map and first-fit run allocation.
//
//   channel | role   | payload
//   --------+--------+------------------------------------------------------
//   req     | sink   | kind, byte_index, byte_value, sector_count
//   res     | source | descriptor_word, read_byte, status, is_last
//
// A write item goes through the output state to its result; a read item first passes
// a read-data state. An allocate item, for each segment, checks, scans the map one
// map byte per cycle through the single memory read port, reads and writes back
// each map byte the run touches, and sends its segment word.
// Reset clears the per-byte valid bits at once, so every map byte reads as free.
// Items are taken one at a time; the output register lets the next item in while
// a result waits, and the machine holds whenever a new result meets a full register.
module bitmap_cluster_run_allocator (
    input  logic              clk,
    input  logic              rst_n,
    bcra_req_if.sink          req,
    bcra_res_if.source        res
);
    import bcra_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ONE_OUT,
        ST_RD_OUT,
        ST_CHECK,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SEG_OUT,
        ST_FAIL
    } state_t;

    // Map storage: one byte per entry, one read and one write port.
    logic [BYTE_W-1:0] map_mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] map_valid_reg;
    logic [BYTE_W-1:0] mem_q_reg;
    logic              mem_q_valid_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [BYTE_W-1:0] mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    logic [BYTE_W-1:0] rd_data;

    // Control and working registers.
    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  hold_byte_reg, hold_byte_next;
    logic               hold_status_reg, hold_status_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [REM_W-1:0]   remaining_reg, remaining_next;
    logic [SEG_W-1:0]   segs_reg, segs_next;
    logic [RUN_W-1:0]   target_reg, target_next;
    logic [RUN_W-1:0]   found_reg, found_next;
    logic [CLU_W-1:0]   start_reg, start_next;
    logic [ADDR_W:0]    scan_addr_reg, scan_addr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]  rd_byte_reg, rd_byte_next;
    logic [ADDR_W-1:0]  mark_addr_reg, mark_addr_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               req_fire;
    logic               idx_in_map;
    logic [COUNT_W:0]   count_plus;
    logic [CLU_W-1:0]   mark_end;
    logic [ADDR_W-1:0]  mark_last;
    logic [BYTE_W-1:0]  mark_mask;
    logic               scan_issue;
    logic [RUN_W-1:0]   byte_found;
    logic [CLU_W-1:0]   byte_start;
    logic               byte_hit;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || res.ready;
    assign idx_in_map = ({1'b0, req.byte_index} < (INDEX_W + 1)'(MAP_BYTES));
    assign count_plus = {1'b0, req.sector_count} + (COUNT_W + 1)'(3);
    assign rd_data    = mem_q_valid_reg ? mem_q_reg : '0;

    assign res.valid           = out_valid_reg;
    assign res.descriptor_word = out_word_reg;
    assign res.read_byte       = out_byte_reg;
    assign res.status          = out_status_reg;
    assign res.is_last         = out_last_reg;

    // Last cluster of the run being marked and its byte.
    assign mark_end   = start_reg + CLU_W'(found_reg) - CLU_W'(1);
    assign mark_last  = mark_end[CLU_W-1:3];
    assign scan_issue = (scan_addr_reg < (ADDR_W + 1)'(MAP_BYTES));

    // Bits of the current mark byte that fall inside the run.
    always_comb
    begin
        logic [CLU_W-1:0] clu;
        for (int j = 0; j < 8; j++)
        begin
            clu = {mark_addr_reg, 3'(j)};
            mark_mask[7 - j] = (clu >= start_reg) && (clu <= mark_end);
        end
    end

    // Walk the eight clusters of the fetched byte, lowest cluster first.
    always_comb
    begin
        byte_found = found_reg;
        byte_start = start_reg;
        byte_hit   = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if (!byte_hit)
            begin
                if (!rd_data[7 - j])
                begin
                    if (byte_found == '0)
                    begin
                        byte_start = {rd_byte_reg, 3'(j)};
                    end
                    byte_found = byte_found + RUN_W'(1);
                    if (byte_found >= target_reg)
                    begin
                        byte_hit = 1'b1;
                    end
                end
                else
                begin
                    byte_found = '0;
                end
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = req.byte_index[ADDR_W-1:0];
        mem_wd = req.byte_value;
        mem_ra = req.byte_index[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                mem_we = req_fire && (req.kind == KIND_WRITE) && idx_in_map;
            end
            ST_SCAN:
            begin
                mem_ra = scan_addr_reg[ADDR_W-1:0];
            end
            ST_MARK_RD:
            begin
                mem_ra = mark_addr_reg;
            end
            ST_MARK_WR:
            begin
                mem_we = 1'b1;
                mem_wa = mark_addr_reg;
                mem_wd = rd_data | mark_mask;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        hold_byte_next   = hold_byte_reg;
        hold_status_next = hold_status_reg;
        count_next       = count_reg;
        remaining_next   = remaining_reg;
        segs_next        = segs_reg;
        target_next      = target_reg;
        found_next       = found_reg;
        start_next       = start_reg;
        scan_addr_next   = scan_addr_reg;
        rd_valid_next    = 1'b0;
        rd_byte_next     = rd_byte_reg;
        mark_addr_next   = mark_addr_reg;

        // Drop the held result once it is taken.
        out_valid_next  = out_valid_reg && !res.ready;
        out_word_next   = out_word_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    hold_status_next = 1'b0;
                    hold_byte_next   = '0;
                    if (req.kind == KIND_WRITE)
                    begin
                        if (idx_in_map)
                        begin
                            hold_byte_next = req.byte_value;
                        end
                        state_next = ST_ONE_OUT;
                    end
                    else if (req.kind == KIND_READ)
                    begin
                        state_next = idx_in_map ? ST_RD_OUT : ST_ONE_OUT;
                    end
                    else if (req.kind == KIND_ALLOC)
                    begin
                        count_next     = req.sector_count;
                        remaining_next = count_plus[COUNT_W:2];
                        segs_next      = '0;
                        state_next     = ST_CHECK;
                    end
                    else
                    begin
                        hold_status_next = 1'b1;
                        state_next       = ST_ONE_OUT;
                    end
                end
            end

            ST_RD_OUT:
            begin
                hold_byte_next = rd_data;
                state_next     = ST_ONE_OUT;
            end

            ST_ONE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = '0;
                    out_byte_next   = hold_byte_reg;
                    out_status_next = hold_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_CHECK:
            begin
                if (remaining_reg == '0)
                begin
                    // All clusters placed: send the end word.
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_word_next   = END_MARK + WORD_W'(count_reg) - WORD_W'(1);
                        out_byte_next   = '0;
                        out_status_next = 1'b0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (segs_reg >= SEG_W'(MAX_SEGMENTS))
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    target_next    = (remaining_reg < REM_W'(MAX_RUN)) ?
                                     remaining_reg[RUN_W-1:0] : RUN_W'(MAX_RUN);
                    found_next     = '0;
                    start_next     = '0;
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg && (byte_hit || rd_byte_reg == ADDR_W'(MAP_BYTES - 1)))
                begin
                    // Run found, or the map ended: take the run touching the end.
                    found_next     = byte_found;
                    start_next     = byte_start;
                    mark_addr_next = byte_start[CLU_W-1:3];
                    state_next     = (byte_found == '0) ? ST_FAIL : ST_MARK_RD;
                end
                else
                begin
                    if (rd_valid_reg)
                    begin
                        found_next = byte_found;
                        start_next = byte_start;
                    end
                    if (scan_issue)
                    begin
                        rd_valid_next  = 1'b1;
                        rd_byte_next   = scan_addr_reg[ADDR_W-1:0];
                        scan_addr_next = scan_addr_reg + (ADDR_W + 1)'(1);
                    end
                end
            end

            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                if (mark_addr_reg == mark_last)
                begin
                    state_next = ST_SEG_OUT;
                end
                else
                begin
                    mark_addr_next = mark_addr_reg + ADDR_W'(1);
                    state_next     = ST_MARK_RD;
                end
            end

            ST_SEG_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = WORD_W'(start_reg)
                                    + (WORD_W'(found_reg - RUN_W'(1)) << LEN_SHIFT);
                    out_byte_next   = '0;
                    out_status_next = 1'b0;
                    out_last_next   = 1'b0;
                    remaining_next  = remaining_reg - REM_W'(found_reg);
                    segs_next       = segs_reg + SEG_W'(1);
                    state_next      = ST_CHECK;
                end
            end

            ST_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = '0;
                    out_byte_next   = '0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
            segs_reg        <= '0;
            target_reg      <= '0;
            found_reg       <= '0;
            hold_byte_reg   <= '0;
            hold_status_reg <= 1'b0;
            count_reg       <= '0;
            remaining_reg   <= '0;
            start_reg       <= '0;
            scan_addr_reg   <= '0;
            rd_byte_reg     <= '0;
            mark_addr_reg   <= '0;
            out_word_reg    <= '0;
            out_byte_reg    <= '0;
            out_status_reg  <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            rd_valid_reg    <= rd_valid_next;
            segs_reg        <= segs_next;
            target_reg      <= target_next;
            found_reg       <= found_next;
            hold_byte_reg   <= hold_byte_next;
            hold_status_reg <= hold_status_next;
            count_reg       <= count_next;
            remaining_reg   <= remaining_next;
            start_reg       <= start_next;
            scan_addr_reg   <= scan_addr_next;
            rd_byte_reg     <= rd_byte_next;
            mark_addr_reg   <= mark_addr_next;
            out_word_reg    <= out_word_next;
            out_byte_reg    <= out_byte_next;
            out_status_reg  <= out_status_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Valid bits: a byte never written reads as all clusters free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg   <= '0;
            mem_q_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                map_valid_reg[mem_wa] <= 1'b1;
            end
            mem_q_valid_reg <= map_valid_reg[mem_ra];
        end
    end

    // Map memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= map_mem[mem_ra];
    end

    `ASSERT_ALWAYS(a_seg_limit, clk, rst_n, segs_reg <= SEG_W'(MAX_SEGMENTS), "segment count over limit")
    `ASSERT_ALWAYS(a_run_bound, clk, rst_n, found_reg <= target_reg, "run longer than target")
    `ASSERT_IMPLIES(a_mark_range, clk, rst_n, state_reg == ST_MARK_WR, mark_addr_reg <= mark_last, "mark past run end")
    `ASSERT_IMPLIES(a_fail_last, clk, rst_n, res.valid && res.status, res.is_last && res.descriptor_word == '0, "failure result not final")

endmodule

### bench/bitmap_cluster_run_allocator_tb.sv
// Self-checking testbench for the cluster bitmap run allocator.
`timescale 1ns / 100ps

module bitmap_cluster_run_allocator_tb;
    import bcra_pkg::*;

    // One request item as the driver presents it.
    typedef struct {
        kind_t              kind;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  val;
        logic [COUNT_W-1:0] count;
    } map_request_t;

    // One result item as the block should return it.
    typedef struct {
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] rbyte;
        logic              status;
        logic              is_final;
    } map_result_t;

    // Longest stretch without any handshake before the run is declared hung.
    // One segment costs a check, a full map scan, a read and write back per
    // touched byte and an output step.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;

    bcra_req_if req_ch ();
    bcra_res_if res_ch ();

    bitmap_cluster_run_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Requests waiting for the driver, and results the block still owes.
    map_request_t pending_requests [$];
    map_result_t  owed_results [$];

    // Shadow copy of the cluster bitmap, updated as requests are accepted.
    logic [BYTE_W-1:0] shadow_map [MAP_BYTES];

    map_request_t on_bus;
    int           sender_idle_pct;
    int           receiver_idle_pct;
    int           mismatches;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model of the allocator
    // ------------------------------------------------------------------

    task automatic owe_result(input logic [WORD_W-1:0] word, input logic [BYTE_W-1:0] rbyte,
                              input logic status, input logic is_final);
        map_result_t r;
        r.word     = word;
        r.rbyte    = rbyte;
        r.status   = status;
        r.is_final = is_final;
        owed_results.push_back(r);
    endtask

    // Apply one accepted request to the shadow map and queue its results.
    task automatic apply_map_request(input map_request_t it);
        int                clusters_left;
        int                segments;
        int                target;
        int                run_start;
        int                run_len;
        int                c;
        bit                finished;
        logic [WORD_W-1:0] word;

        case (it.kind)
            KIND_WRITE:
            begin
                shadow_map[it.idx] = it.val;
                owe_result('0, it.val, 1'b0, 1'b1);
            end
            KIND_READ:
            begin
                owe_result('0, shadow_map[it.idx], 1'b0, 1'b1);
            end
            KIND_ALLOC:
            begin
                clusters_left = (int'(it.count) + 3) >> 2;
                segments      = 0;
                finished      = 1'b0;
                while (!finished)
                begin
                    if (clusters_left == 0)
                    begin
                        word = END_MARK + WORD_W'(it.count) - WORD_W'(1);
                        owe_result(word, '0, 1'b0, 1'b1);
                        finished = 1'b1;
                    end
                    else if (segments >= MAX_SEGMENTS)
                    begin
                        owe_result('0, '0, 1'b1, 1'b1);
                        finished = 1'b1;
                    end
                    else
                    begin
                        // First fit: stop at the first free run that reaches the
                        // target; otherwise the run touching the last cluster stays.
                        target    = (clusters_left < MAX_RUN) ? clusters_left : MAX_RUN;
                        run_start = 0;
                        run_len   = 0;
                        for (c = 0; c < NUM_CLUSTERS && run_len < target; c++)
                        begin
                            if (shadow_map[c >> 3][7 - (c & 7)] == 1'b0)
                            begin
                                if (run_len == 0)
                                    run_start = c;
                                run_len++;
                            end
                            else
                                run_len = 0;
                        end
                        if (run_len == 0)
                        begin
                            // No space: earlier segments stay marked.
                            owe_result('0, '0, 1'b1, 1'b1);
                            finished = 1'b1;
                        end
                        else
                        begin
                            for (c = run_start; c < run_start + run_len; c++)
                                shadow_map[c >> 3][7 - (c & 7)] = 1'b1;
                            word = WORD_W'(run_start + ((run_len - 1) << LEN_SHIFT));
                            owe_result(word, '0, 1'b0, 1'b0);
                            segments++;
                            clusters_left -= run_len;
                        end
                    end
                end
            end
            default:
            begin
                owe_result('0, '0, 1'b1, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers; fields a kind ignores carry random junk
    // ------------------------------------------------------------------

    task automatic queue_write(input int idx, input int val);
        map_request_t it;
        it.kind  = KIND_WRITE;
        it.idx   = idx[INDEX_W-1:0];
        it.val   = val[BYTE_W-1:0];
        it.count = COUNT_W'($urandom_range(1, 4096));
        pending_requests.push_back(it);
    endtask

    task automatic queue_read(input int idx);
        map_request_t it;
        it.kind  = KIND_READ;
        it.idx   = idx[INDEX_W-1:0];
        it.val   = BYTE_W'($urandom);
        it.count = COUNT_W'($urandom_range(1, 4096));
        pending_requests.push_back(it);
    endtask

    task automatic queue_alloc(input int count);
        map_request_t it;
        it.kind  = KIND_ALLOC;
        it.idx   = INDEX_W'($urandom);
        it.val   = BYTE_W'($urandom);
        it.count = count[COUNT_W-1:0];
        pending_requests.push_back(it);
    endtask

    // Map byte mix: free bytes most often so allocations keep finding room,
    // with full and fragmented bytes to break runs apart.
    function automatic int pick_map_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 0;
        else if (sel < 55)
            return 8'hFF;
        else if (sel < 70)
            return 1 << $urandom_range(7);
        else
            return $urandom_range(255);
    endfunction

    // Mostly small requests; a few reach for most or all of the map.
    function automatic int pick_sector_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom_range(1, 64);
        else if (sel < 85)
            return $urandom_range(65, 512);
        else if (sel < 97)
            return $urandom_range(513, 2048);
        else
            return $urandom_range(2049, 4096);
    endfunction

    // Queue random episodes: reshape part of the map, allocate, read back.
    task automatic queue_random_phase(input int item_goal);
        int queued;
        int n;
        int base;
        queued = 0;
        while (queued < item_goal)
        begin
            if ($urandom_range(7) == 0)
            begin
                // Free a whole stretch of the map so long runs come back.
                base = $urandom_range(MAP_BYTES - 1);
                for (n = 0; n < 12; n++)
                    queue_write((base + n) % MAP_BYTES, 0);
                queued += 12;
            end
            n = $urandom_range(2, 8);
            queued += n;
            repeat (n) queue_write($urandom_range(MAP_BYTES - 1), pick_map_byte());
            n = $urandom_range(1, 3);
            queued += n;
            repeat (n) queue_alloc(pick_sector_count());
            n = $urandom_range(1, 3);
            queued += n;
            repeat (n) queue_read($urandom_range(MAP_BYTES - 1));
        end
    endtask

    // Hold the sender until every owed result is back.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || req_ch.valid || owed_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next pending item, predict on acceptance
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
                apply_map_request(on_bus);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_bus = pending_requests.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.kind         <= on_bus.kind;
                    req_ch.byte_index   <= on_bus.idx;
                    req_ch.byte_value   <= on_bus.val;
                    req_ch.sector_count <= on_bus.count;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest owed one
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: descriptor_word %h read_byte %h status %b",
                           res_ch.descriptor_word, res_ch.read_byte, res_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res_ch.descriptor_word !== want.word)
                    begin
                        $error("descriptor_word: expected %h, got %h",
                               want.word, res_ch.descriptor_word);
                        mismatches++;
                    end
                    if (res_ch.read_byte !== want.rbyte)
                    begin
                        $error("read_byte: expected %h, got %h", want.rbyte, res_ch.read_byte);
                        mismatches++;
                    end
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %b, got %b", want.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.is_last !== want.is_final)
                    begin
                        $error("is_last: expected %b, got %b", want.is_final, res_ch.is_last);
                        mismatches++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, then three random phases
    // ------------------------------------------------------------------

    initial
    begin
        int i;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_WRITE;
        req_ch.byte_index    = '0;
        req_ch.byte_value    = '0;
        req_ch.sector_count  = '0;
        res_ch.ready         = 1'b0;
        mismatches           = 0;
        quiet_cycles         = 0;
        sender_idle_pct      = 18;
        receiver_idle_pct    = 51;
        for (i = 0; i < MAP_BYTES; i++)
            shadow_map[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Map reads as free after reset, at both ends.
        queue_read(0);
        queue_read(MAP_BYTES - 1);
        // Extreme byte values and indexes.
        queue_write(0, 8'hFF);
        queue_write(MAP_BYTES - 1, 8'h00);
        queue_write(5, 8'hA5);
        // Smallest requests, one full cluster, a split across two clusters.
        queue_alloc(1);
        queue_alloc(4);
        queue_alloc(5);
        // Exactly one maximal run, then one cluster more than a run.
        queue_alloc(128);
        queue_alloc(129);
        // Largest request: eats every run, falls back to the tail run,
        // then runs out of space with its marks left in place.
        queue_alloc(4096);
        queue_read(64);
        queue_read(5);
        // Only short fragments are left: a single cluster still fits in one.
        queue_alloc(1);
        // Free 15 clusters just before a taken last cluster: no run reaches
        // the target and there is no tail run, so it fails with no segment.
        queue_write(126, 8'h00);
        queue_write(127, 8'h01);
        queue_alloc(200);
        // A 31-cluster run and a 16-cluster tail: the tail fallback comes
        // first, then the remaining 31 fit exactly.
        queue_write(10, 8'h00);
        queue_write(11, 8'h00);
        queue_write(12, 8'h00);
        queue_write(13, 8'h01);
        queue_write(126, 8'h00);
        queue_write(127, 8'h00);
        queue_alloc(188);
        queue_read(13);
        // The segment cap cannot trigger with this map size: full runs take
        // 32 clusters each and the tail fallback happens at most once.
        wait_until_drained();

        queue_random_phase(150);
        wait_until_drained();

        sender_idle_pct   = 51;
        receiver_idle_pct = 18;
        queue_random_phase(150);
        wait_until_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random_phase(155);
        wait_until_drained();

        // Give any stray result time to show up before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
